@@ design/arpc_pkg.sv @@
package arpc_pkg;

    // Counter limit for length, printable count and run length.
    localparam int MAX_PACKET_BYTES = 16384;
    localparam int CNT_W            = 15;
    localparam int PCT_W            = 7;
    localparam int BYTE_W           = 8;
    localparam int PCT_SCALE        = 100;
    // Both sides of the percentage test: 100 * 16384 and 127 * 16384 fit.
    localparam int PROD_W           = 22;
    localparam int CFG_IDX_W        = 3;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PROD_W-1:0] prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RUN_THRESHOLD     = 3'd0,
        REG_PERCENT_THRESHOLD = 3'd1,
        REG_MIN_HEADER_LEN    = 3'd2,
        REG_MAX_HEADER_LEN    = 3'd3,
        REG_PRINTABLE_LOW     = 3'd4,
        REG_PRINTABLE_HIGH    = 3'd5
    } cfg_index_t;

    localparam cnt_t               RST_RUN_THRESHOLD     = cnt_t'(0);
    localparam logic [PCT_W-1:0]   RST_PERCENT_THRESHOLD = PCT_W'(0);
    localparam cnt_t               RST_MIN_HEADER_LEN    = cnt_t'(42);
    localparam cnt_t               RST_MAX_HEADER_LEN    = cnt_t'(64);
    localparam logic [BYTE_W-1:0]  RST_PRINTABLE_LOW     = BYTE_W'(32);
    localparam logic [BYTE_W-1:0]  RST_PRINTABLE_HIGH    = BYTE_W'(126);

    // Per-packet totals handed from the scan stage to the decision stage.
    typedef struct packed {
        cnt_t len;
        cnt_t count;
        logic hit;
    } pkt_sum_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v < cnt_t'(MAX_PACKET_BYTES)) ? cnt_t'(v + 1'b1)
                                              : cnt_t'(MAX_PACKET_BYTES);
    endfunction

endpackage

@@ design/ascii_run_packet_capper.sv @@
// Capture-length decision for a byte stream of packets. Words on the s_ side
// carry one packet byte and a last-byte mark; for every packet one result word
// leaves on the m_ side, carrying the bytes to keep (capture_len), the counted
// packet length (wire_len, saturating at 16384) and a flag telling whether the
// packet was cut to max_header_len. Short packets are kept whole; longer ones
// are cut when a printable run reaches run_threshold (0 turns this rule off),
// else kept only if 100 * printable >= percent * (length - min_header_len).
// The block takes one byte per cycle while the result side is not stalled: the
// per-byte counter update and the end-of-packet decision each sit between two
// registers, so a last byte passes the input register, the packet summary
// register and the output register in turn. The user must write configuration
// through cfg_wr_en/cfg_wr_index/cfg_wr_data only while no packet is in flight;
// the block does not enforce this. Writes to unknown indexes are dropped.
module ascii_run_packet_capper
    import arpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CNT_W-1:0]      cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,
    input  logic                  s_last_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CNT_W-1:0]      m_capture_len,
    output logic [CNT_W-1:0]      m_wire_len,
    output logic                  m_truncated
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cnt_t              run_thr_reg;
    logic [PCT_W-1:0]  pct_thr_reg;
    cnt_t              min_hdr_reg;
    cnt_t              max_hdr_reg;
    logic [BYTE_W-1:0] prn_low_reg;
    logic [BYTE_W-1:0] prn_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_thr_reg  <= RST_RUN_THRESHOLD;
            pct_thr_reg  <= RST_PERCENT_THRESHOLD;
            min_hdr_reg  <= RST_MIN_HEADER_LEN;
            max_hdr_reg  <= RST_MAX_HEADER_LEN;
            prn_low_reg  <= RST_PRINTABLE_LOW;
            prn_high_reg <= RST_PRINTABLE_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_RUN_THRESHOLD:     run_thr_reg  <= cfg_wr_data;
                REG_PERCENT_THRESHOLD: pct_thr_reg  <= cfg_wr_data[PCT_W-1:0];
                REG_MIN_HEADER_LEN:    min_hdr_reg  <= cfg_wr_data;
                REG_MAX_HEADER_LEN:    max_hdr_reg  <= cfg_wr_data;
                REG_PRINTABLE_LOW:     prn_low_reg  <= cfg_wr_data[BYTE_W-1:0];
                REG_PRINTABLE_HIGH:    prn_high_reg <= cfg_wr_data[BYTE_W-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage advances when the one after it
    // is empty or advancing; the output register frees on m_ready.
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic              sum_valid_reg;
    pkt_sum_t          sum_reg;

    logic              out_valid_reg;
    cnt_t              out_cap_reg;
    cnt_t              out_len_reg;
    logic              out_cut_reg;

    logic out_free;
    logic sum_free;
    logic in_free;
    logic in_fire;

    assign out_free = !out_valid_reg || m_ready;
    assign sum_free = !sum_valid_reg || out_free;
    assign in_free  = !in_valid_reg || sum_free;
    assign in_fire  = in_valid_reg && sum_free;  // byte leaves the input register
    assign s_ready  = in_free;

    // Input register: hold the accepted word until the scan stage takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_free) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // ------------------------------------------------------------------
    // Scan stage: per-packet counters, updated once per byte.
    // ------------------------------------------------------------------
    cnt_t pos_reg,   pos_next;
    cnt_t count_reg, count_next;
    cnt_t run_reg,   run_next;
    logic hit_reg,   hit_next;

    logic scan_on;
    logic printable;
    cnt_t pos_inc;
    cnt_t count_upd;
    cnt_t run_upd;
    logic hit_upd;

    always_comb begin
        scan_on   = pos_reg >= min_hdr_reg;
        printable = (in_byte_reg >= prn_low_reg) && (in_byte_reg <= prn_high_reg);
        pos_inc   = sat_inc(pos_reg);
        count_upd = count_reg;
        run_upd   = run_reg;
        hit_upd   = hit_reg;
        if (scan_on) begin
            if (printable) begin
                run_upd   = sat_inc(run_reg);
                count_upd = sat_inc(count_reg);
                // A zero threshold never matches, since the run is at least one here.
                if (run_upd == run_thr_reg) begin
                    hit_upd = 1'b1;
                end
            end else begin
                run_upd = '0;
            end
        end

        pos_next   = pos_reg;
        count_next = count_reg;
        run_next   = run_reg;
        hit_next   = hit_reg;
        if (in_fire) begin
            if (in_last_reg) begin
                // End of packet: clear for the next one.
                pos_next   = '0;
                count_next = '0;
                run_next   = '0;
                hit_next   = 1'b0;
            end else begin
                pos_next   = pos_inc;
                count_next = count_upd;
                run_next   = run_upd;
                hit_next   = hit_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
            run_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            hit_reg   <= hit_next;
        end
    end

    // Packet summary register: loaded only on the last byte of a packet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_free) begin
            sum_valid_reg <= in_fire && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_last_reg) begin
            sum_reg.len   <= pos_inc;
            sum_reg.count <= count_upd;
            sum_reg.hit   <= hit_upd;
        end
    end

    // ------------------------------------------------------------------
    // Decision stage: short packet, run rule, then the percentage test.
    // ------------------------------------------------------------------
    cnt_t  span;
    prod_t pct_lhs;
    prod_t pct_rhs;
    cnt_t  cap_calc;
    logic  cut_calc;

    always_comb begin
        span    = (sum_reg.len > min_hdr_reg) ? cnt_t'(sum_reg.len - min_hdr_reg) : '0;
        pct_lhs = prod_t'(sum_reg.count) * prod_t'(PCT_SCALE);
        pct_rhs = prod_t'(pct_thr_reg) * prod_t'(span);
        priority if (max_hdr_reg >= sum_reg.len) begin
            cap_calc = sum_reg.len;
            cut_calc = 1'b0;
        end else if (sum_reg.hit) begin
            cap_calc = max_hdr_reg;
            cut_calc = 1'b1;
        end else if (pct_lhs >= pct_rhs) begin
            cap_calc = sum_reg.len;
            cut_calc = 1'b0;
        end else begin
            cap_calc = max_hdr_reg;
            cut_calc = 1'b1;
        end
    end

    // Output register: hold the result word until m_ready takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && sum_valid_reg) begin
            out_cap_reg <= cap_calc;
            out_len_reg <= sum_reg.len;
            out_cut_reg <= cut_calc;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_capture_len = out_cap_reg;
    assign m_wire_len    = out_len_reg;
    assign m_truncated   = out_cut_reg;

endmodule

@@ design/arpc_checker.sv @@
module arpc_checker
    import arpc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [CNT_W-1:0]     m_capture_len,
    input logic [CNT_W-1:0]     m_wire_len,
    input logic                 m_truncated
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_capture_len)
            && $stable(m_wire_len) && $stable(m_truncated))
        else $error("result word changed while stalled");

    // A cut packet is shorter on capture than on the wire.
    a_cut_shorter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_capture_len < m_wire_len)
        else $error("truncated result not shorter than wire length");

    // A packet kept whole captures its full length.
    a_whole_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_truncated |-> m_capture_len == m_wire_len)
        else $error("whole packet capture length differs from wire length");

    // Every packet holds at least one byte and no more than the limit.
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_wire_len != '0) && (m_wire_len <= CNT_W'(MAX_PACKET_BYTES)))
        else $error("wire length out of range");

    // Reset empties the output side.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind ascii_run_packet_capper arpc_checker u_arpc_checker (.*);

@@ sim/arpc_cap_check.sv @@
`timescale 1ns / 1ps
module arpc_cap_check
    import arpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic                 s_last_byte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  cnt_t                 m_capture_len,
    input  cnt_t                 m_wire_len,
    input  logic                 m_truncated,
    output int                   err_count,
    output int                   pending
);

    typedef struct packed {
        cnt_t capture_len;
        cnt_t wire_len;
        logic truncated;
    } cap_word_t;

    cap_word_t caps_due[$];

    // Register copies.
    cnt_t              run_limit;
    logic [PCT_W-1:0]  pct_floor;
    cnt_t              scan_start;
    cnt_t              cut_len;
    logic [BYTE_W-1:0] print_lo;
    logic [BYTE_W-1:0] print_hi;

    // Per-packet scan state.
    cnt_t pos_cnt;
    cnt_t print_cnt;
    cnt_t run_len;
    logic run_seen;

    function automatic cnt_t bump(input cnt_t v);
        return (v == cnt_t'(MAX_PACKET_BYTES)) ? v : v + cnt_t'(1);
    endfunction

    task automatic clear_scan();
        pos_cnt   = '0;
        print_cnt = '0;
        run_len   = '0;
        run_seen  = 1'b0;
    endtask

    // Advance the scan by one byte; on the last byte, queue the capture decision.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        cap_word_t r;
        longint    span;
        if (pos_cnt >= scan_start) begin
            if (b >= print_lo && b <= print_hi) begin
                run_len   = bump(run_len);
                print_cnt = bump(print_cnt);
                if (run_len == run_limit)
                    run_seen = 1'b1;
            end else begin
                run_len = '0;
            end
        end
        pos_cnt = bump(pos_cnt);
        if (last) begin
            r.wire_len    = pos_cnt;
            r.capture_len = pos_cnt;
            r.truncated   = 1'b0;
            if (cut_len < pos_cnt) begin
                span = (pos_cnt > scan_start) ? longint'(pos_cnt) - longint'(scan_start) : 0;
                if (run_seen ||
                    longint'(PCT_SCALE) * longint'(print_cnt) < longint'(pct_floor) * span) begin
                    r.capture_len = cut_len;
                    r.truncated   = 1'b1;
                end
            end
            caps_due.push_back(r);
            clear_scan();
        end
    endtask

    always @(posedge aclk) begin
        cap_word_t want;
        if (!aresetn) begin
            run_limit  = RST_RUN_THRESHOLD;
            pct_floor  = RST_PERCENT_THRESHOLD;
            scan_start = RST_MIN_HEADER_LEN;
            cut_len    = RST_MAX_HEADER_LEN;
            print_lo   = RST_PRINTABLE_LOW;
            print_hi   = RST_PRINTABLE_HIGH;
            clear_scan();
            caps_due.delete();
            err_count  = 0;
            pending   <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    REG_RUN_THRESHOLD:     run_limit  = cfg_wr_data;
                    REG_PERCENT_THRESHOLD: pct_floor  = cfg_wr_data[PCT_W-1:0];
                    REG_MIN_HEADER_LEN:    scan_start = cfg_wr_data;
                    REG_MAX_HEADER_LEN:    cut_len    = cfg_wr_data;
                    REG_PRINTABLE_LOW:     print_lo   = cfg_wr_data[BYTE_W-1:0];
                    REG_PRINTABLE_HIGH:    print_hi   = cfg_wr_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                scan_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (caps_due.size() == 0) begin
                    $error("unexpected word: capture_len %0d wire_len %0d truncated %0d",
                           m_capture_len, m_wire_len, m_truncated);
                    err_count++;
                end else begin
                    want = caps_due.pop_front();
                    if (m_capture_len !== want.capture_len) begin
                        $error("capture_len: expected %0d, actual %0d",
                               want.capture_len, m_capture_len);
                        err_count++;
                    end
                    if (m_wire_len !== want.wire_len) begin
                        $error("wire_len: expected %0d, actual %0d",
                               want.wire_len, m_wire_len);
                        err_count++;
                    end
                    if (m_truncated !== want.truncated) begin
                        $error("truncated: expected %0d, actual %0d",
                               want.truncated, m_truncated);
                        err_count++;
                    end
                end
            end
            pending <= caps_due.size();
        end
    end

endmodule

@@ sim/tb_ascii_run_packet_capper.sv @@
`timescale 1ns / 1ps
module tb_ascii_run_packet_capper;
    import arpc_pkg::*;

    // Quiet cycles (no word moving on either side) before the run is called dead.
    localparam int QUIET_LIMIT       = 4000;
    // Cycles to let the pipeline empty after the last expected word.
    localparam int DRAIN_CYCLES      = 8;
    // Random words to send under each register setting.
    localparam int WORDS_PER_SETTING = 115;
    // Indexes past the register map; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef logic [BYTE_W-1:0] octet_q_t[$];

    typedef struct packed {
        cnt_t              run_thr;
        logic [PCT_W-1:0]  pct;
        cnt_t              min_hdr;
        cnt_t              max_hdr;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
    } capper_cfg_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index  = '0;
    logic [CNT_W-1:0]     cfg_wr_data   = '0;
    logic                 s_valid       = 1'b0;
    logic [BYTE_W-1:0]    s_data_byte   = '0;
    logic                 s_last_byte   = 1'b0;
    logic                 m_ready       = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    cnt_t                 m_capture_len;
    cnt_t                 m_wire_len;
    logic                 m_truncated;

    int err_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    ascii_run_packet_capper DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_capture_len (m_capture_len),
        .m_wire_len    (m_wire_len),
        .m_truncated   (m_truncated)
    );

    // Predict and compare on the side; the verdict reads its failure count.
    arpc_cap_check cap_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_capture_len (m_capture_len),
        .m_wire_len    (m_wire_len),
        .m_truncated   (m_truncated),
        .err_count     (err_count),
        .pending       (pending)
    );

    // Stall the result side at random, one decision per cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: restart on every moved word, give up after a long quiet stretch.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic capper_cfg_t mk_cfg(input int run_thr, input int pct, input int min_hdr,
                                           input int max_hdr, input int lo, input int hi);
        capper_cfg_t c;
        c.run_thr = cnt_t'(run_thr);
        c.pct     = PCT_W'(pct);
        c.min_hdr = cnt_t'(min_hdr);
        c.max_hdr = cnt_t'(max_hdr);
        c.lo      = BYTE_W'(lo);
        c.hi      = BYTE_W'(hi);
        return c;
    endfunction

    // Keep headers and cut lengths small so that every rule fires often.
    function automatic capper_cfg_t random_cfg();
        int lo;
        int hi;
        lo = $urandom_range(160, 0);
        hi = $urandom_range(255, lo);
        // Occasionally flip the bounds to get an empty printable range.
        if ($urandom_range(7) == 0)
            return mk_cfg($urandom_range(12, 0), $urandom_range(100, 0), $urandom_range(20, 0),
                          $urandom_range(40, 0), hi, lo);
        return mk_cfg($urandom_range(12, 0), $urandom_range(100, 0), $urandom_range(20, 0),
                      $urandom_range(40, 0), lo, hi);
    endfunction

    // Register extremes, one per idling phase.
    function automatic capper_cfg_t extreme_cfg(input int phase);
        case (phase)
            0:       return mk_cfg(MAX_PACKET_BYTES, 100, MAX_PACKET_BYTES, MAX_PACKET_BYTES,
                               0, 255);
            1:       return mk_cfg(1, 100, 0, 0, 0, 255);
            default: return mk_cfg(0, 0, 0, 0, 255, 0);
        endcase
    endfunction

    // Draw a byte: inside the printable range with the given share, else anything.
    function automatic logic [BYTE_W-1:0] pick_byte(input capper_cfg_t c, input int share);
        logic [BYTE_W-1:0] b;
        if (c.lo <= c.hi && $urandom_range(99) < share)
            b = BYTE_W'($urandom_range(c.hi, c.lo));
        else
            b = BYTE_W'($urandom_range(255, 0));
        return b;
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input cnt_t val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
    endtask

    // Write every register, then poke an unmapped index; that write must not land.
    task automatic program_regs(input capper_cfg_t c);
        put_reg(REG_RUN_THRESHOLD,     c.run_thr);
        put_reg(REG_PERCENT_THRESHOLD, cnt_t'(c.pct));
        put_reg(REG_MIN_HEADER_LEN,    c.min_hdr);
        put_reg(REG_MAX_HEADER_LEN,    c.max_hdr);
        put_reg(REG_PRINTABLE_LOW,     cnt_t'(c.lo));
        put_reg(REG_PRINTABLE_HIGH,    cnt_t'(c.hi));
        put_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, cnt_t'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one word, with random idle cycles ahead of it; return at its acceptance edge.
    // Valid stays high across back-to-back words, so it is never dropped and raised
    // in the same step.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_bytes(input octet_q_t seq);
        foreach (seq[i])
            send_word(seq[i], i == seq.size() - 1);
    endtask

    // Drop valid and hold until every expected word is out and the pipeline is empty.
    // The first edge lets the count catch up with the word accepted just now.
    task automatic settle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        capper_cfg_t c;
        int          len;
        int          share;
        int          sent;
        int          span_max;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 37;
        recv_idle_pct = 87;

        // Reset settings: one-byte packets at both ends of the byte range.
        send_bytes('{8'h00});
        send_bytes('{8'hFF});

        // Tiny headers, digits printable: cut by a run of three, a percentage pass
        // right at the limit, and a percentage fail.
        settle();
        program_regs(mk_cfg(3, 50, 2, 4, 8'h30, 8'h39));
        send_bytes('{8'h00, 8'hFF, 8'h31, 8'h32, 8'h33, 8'h00});
        send_bytes('{8'h41, 8'h42, 8'h30, 8'h00, 8'h31, 8'h00});
        send_bytes('{8'h30, 8'h30, 8'h00, 8'hFF, 8'h00, 8'h31});

        // Empty printable range, minimum header past the packet end and above the
        // maximum header: the scanned span is zero, so keep the packet whole.
        settle();
        program_regs(mk_cfg(0, 100, 10, 2, 8'h80, 8'h7F));
        send_bytes('{8'h80, 8'h7F, 8'h00, 8'hFF});

        // Random packets under three idling patterns; each phase opens with an
        // extreme setting, then moves through random ones.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 87;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 5; k++) begin
                settle();
                c = (k == 0) ? extreme_cfg(phase) : random_cfg();
                program_regs(c);
                sent = 0;
                while (sent < WORDS_PER_SETTING) begin
                    // Lengths straddle the cut length; printable share sets run odds.
                    span_max = (c.max_hdr < 48) ? int'(c.max_hdr) + 16 : 64;
                    len      = $urandom_range(span_max, 1);
                    share    = 25 * $urandom_range(4, 0);
                    for (int i = 0; i < len; i++)
                        send_word(pick_byte(c, share), i == len - 1);
                    sent += len;
                    // Now and then hold the sender until the result side is empty.
                    if ($urandom_range(19) == 0)
                        settle();
                end
            end
        end

        settle();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
